// File: rtl/core/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types, codes and constants of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int MAX_BLOCKS = 256;
  localparam int PTR_BYTES  = 4;
  localparam int IDX_W      = 8;
  localparam int CNT_W      = 9;
  localparam int EFF_W      = 17;
  localparam int ADDR_W     = 32;
  localparam int REQ_W      = 16;
  localparam int BUF_W      = 24;
  localparam int Q_DEPTH    = 2;

  localparam logic [CNT_W-1:0] HEAD_EMPTY = CNT_W'(MAX_BLOCKS);

  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_INIT  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NULL_FREE = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_FREE,
    OP_NULL_FREE,
    OP_INIT,
    OP_NOP
  } op_kind_t;

  typedef struct packed {
    op_kind_t         kind;
    logic [IDX_W-1:0] idx;
  } op_t;

  typedef enum logic [1:0] {
    CFG_BASE      = 2'd0,
    CFG_REQ_BYTES = 2'd1,
    CFG_BUF_BYTES = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [REQ_W-1:0]  req_bytes;
    logic [BUF_W-1:0]  pool_bytes;
  } cfg_t;

  typedef struct packed {
    status_t           status;
    logic [IDX_W-1:0]  block_index;
    logic [ADDR_W-1:0] block_address;
    logic [CNT_W-1:0]  free_count;
    logic [CNT_W-1:0]  blk_total;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_RES
  } bk_state_t;

  // Round up to a whole number of pointers, never below one pointer.
  function automatic logic [EFF_W-1:0] eff_bytes(input logic [REQ_W-1:0] req);
    logic [EFF_W-1:0] r;
    r = (EFF_W'(req) + EFF_W'(PTR_BYTES - 1)) & ~EFF_W'(PTR_BYTES - 1);
    if (r < EFF_W'(PTR_BYTES)) begin
      r = EFF_W'(PTR_BYTES);
    end
    return r;
  endfunction

endpackage

// File: rtl/core/fbpa_ram.sv
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fbpa_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/fbpa_front.sv
// ----------------------------------------------------------------------------
// fbpa_front
// Input side: takes request beats and decodes them into queue entries.
// ----------------------------------------------------------------------------
module fbpa_front (
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_func,
  input  logic [fbpa_pkg::IDX_W-1:0] in_free_index,
  input  logic                      in_free_is_null,
  input  logic                      q_full,
  output logic                      q_push,
  output fbpa_pkg::op_t             q_op
);

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_op.idx = in_free_index;
    unique case (in_func)
      fbpa_pkg::FUNC_ALLOC: q_op.kind = fbpa_pkg::OP_ALLOC;
      fbpa_pkg::FUNC_FREE:  q_op.kind = in_free_is_null ? fbpa_pkg::OP_NULL_FREE
                                                         : fbpa_pkg::OP_FREE;
      fbpa_pkg::FUNC_INIT:  q_op.kind = fbpa_pkg::OP_INIT;
      default:              q_op.kind = fbpa_pkg::OP_NOP;
    endcase
  end

endmodule

// File: rtl/core/fbpa_queue.sv
// ----------------------------------------------------------------------------
// fbpa_queue
// Short FIFO of decoded operations between front and back end.
// ----------------------------------------------------------------------------
module fbpa_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fbpa_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output fbpa_pkg::op_t head_op
);

  localparam int PTR_W = (fbpa_pkg::Q_DEPTH > 1) ? $clog2(fbpa_pkg::Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(fbpa_pkg::Q_DEPTH + 1);

  fbpa_pkg::op_t    entry_r [fbpa_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CNT_W'(fbpa_pkg::Q_DEPTH));
  assign valid   = (cnt_r != '0);
  assign head_op = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(fbpa_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(fbpa_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// File: rtl/core/fbpa_div.sv
// ----------------------------------------------------------------------------
// fbpa_div
// Block count unit: buffer bytes / block bytes, saturated at MAX_BLOCKS,
// one quotient bit per cycle (restoring).
// ----------------------------------------------------------------------------
module fbpa_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [fbpa_pkg::BUF_W-1:0]  dividend,
  input  logic [fbpa_pkg::EFF_W-1:0]  divisor,
  output logic                        done,
  output logic [fbpa_pkg::CNT_W-1:0]  quotient
);

  localparam int IW    = fbpa_pkg::IDX_W;
  localparam int QW    = fbpa_pkg::CNT_W;
  localparam int RW    = fbpa_pkg::EFF_W + IW;
  localparam int STEPW = $clog2(IW + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [STEPW-1:0] step_r, step_nxt;
  logic [RW-1:0]    rem_r, rem_nxt;
  logic [RW-1:0]    dsr_r, dsr_nxt;
  logic [QW-1:0]    q_r, q_nxt;
  logic             ge;

  assign ge = (rem_r >= dsr_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEPW'(IW);
      rem_nxt  = RW'(dividend);
      dsr_nxt  = {divisor, {IW{1'b0}}};
      q_nxt    = '0;
    end else if (busy_r) begin
      if (step_r == STEPW'(IW) && ge) begin
        // buffer holds at least MAX_BLOCKS blocks
        q_nxt    = QW'(fbpa_pkg::MAX_BLOCKS);
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (ge) begin
          rem_nxt = rem_r - dsr_r;
        end
        q_nxt   = {q_r[QW-2:0], ge};
        dsr_nxt = dsr_r >> 1;
        if (step_r == '0) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// File: rtl/core/fbpa_back.sv
// ----------------------------------------------------------------------------
// fbpa_back
// Back end: executes queued operations on the free list and drives the
// result register.
// ----------------------------------------------------------------------------
module fbpa_back (
  input  logic              clk,
  input  logic              rst_n,
  input  fbpa_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  fbpa_pkg::op_t     q_op,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output fbpa_pkg::result_t out_res
);

  localparam int IW = fbpa_pkg::IDX_W;
  localparam int CW = fbpa_pkg::CNT_W;
  localparam int EW = fbpa_pkg::EFF_W;
  localparam int AW = fbpa_pkg::ADDR_W;
  localparam int MW = $clog2(fbpa_pkg::MAX_BLOCKS);

  fbpa_pkg::bk_state_t state_r, state_nxt;
  logic [CW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       top_r, top_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       total_r, total_nxt;
  logic [EW-1:0]       eff_r, eff_nxt;
  logic [IW-1:0]       got_r, got_nxt;
  fbpa_pkg::status_t   status_r, status_nxt;
  logic                addr_en_r, addr_en_nxt;
  logic                link_pend_r, link_pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  fbpa_pkg::result_t   out_res_r, out_res_nxt;

  logic                out_load;
  logic                div_start;
  logic                div_done;
  logic [CW-1:0]       div_q;
  logic                ram_we;
  logic                ram_re;
  logic [CW-1:0]       ram_rdata;
  logic                in_range;
  logic [IW+EW-1:0]    prod;
  logic [AW-1:0]       addr;

  assign in_range = ({1'b0, q_op.idx} < total_r);
  assign prod     = {{EW{1'b0}}, got_r} * {{IW{1'b0}}, eff_r};
  assign addr     = cfg.base + AW'(prod);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fbpa_pkg::BK_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_op.kind == fbpa_pkg::OP_INIT) ? fbpa_pkg::BK_DIV
                                                        : fbpa_pkg::BK_RES;
        end
      end
      fbpa_pkg::BK_DIV: begin
        if (div_done) state_nxt = fbpa_pkg::BK_RES;
      end
      fbpa_pkg::BK_RES: begin
        if (out_load) state_nxt = fbpa_pkg::BK_IDLE;
      end
      default: state_nxt = fbpa_pkg::BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop     = 1'b0;
    out_load  = 1'b0;
    div_start = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    unique case (state_r)
      fbpa_pkg::BK_IDLE: begin
        q_pop     = q_valid;
        div_start = q_valid && (q_op.kind == fbpa_pkg::OP_INIT);
        ram_re    = q_valid && (q_op.kind == fbpa_pkg::OP_ALLOC) &&
                    (head_r != fbpa_pkg::HEAD_EMPTY);
        ram_we    = q_valid && (q_op.kind == fbpa_pkg::OP_FREE) && in_range;
      end
      fbpa_pkg::BK_DIV: begin
      end
      fbpa_pkg::BK_RES: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
      end
    endcase
  end

  // datapath
  always_comb begin
    head_nxt      = head_r;
    top_nxt       = top_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    eff_nxt       = eff_r;
    got_nxt       = got_r;
    status_nxt    = status_r;
    addr_en_nxt   = addr_en_r;
    link_pend_nxt = link_pend_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;

    if (q_pop) begin
      status_nxt  = fbpa_pkg::ST_OK;
      got_nxt     = '0;
      addr_en_nxt = 1'b0;
      unique case (q_op.kind)
        fbpa_pkg::OP_ALLOC: begin
          if (head_r != fbpa_pkg::HEAD_EMPTY) begin
            // pop list head; its link arrives from the RAM next cycle
            got_nxt       = head_r[IW-1:0];
            link_pend_nxt = 1'b1;
            addr_en_nxt   = 1'b1;
            if (count_r != '0) count_nxt = count_r - 1'b1;
          end else if (top_r != '0) begin
            top_nxt     = top_r - 1'b1;
            got_nxt     = IW'(top_r - 1'b1);
            addr_en_nxt = 1'b1;
            if (count_r != '0) count_nxt = count_r - 1'b1;
          end else begin
            status_nxt = fbpa_pkg::ST_EMPTY;
          end
        end
        fbpa_pkg::OP_FREE: begin
          if (in_range) begin
            head_nxt = {1'b0, q_op.idx};
            if (count_r < total_r) count_nxt = count_r + 1'b1;
          end else begin
            status_nxt = fbpa_pkg::ST_BAD_INDEX;
          end
        end
        fbpa_pkg::OP_NULL_FREE: status_nxt = fbpa_pkg::ST_NULL_FREE;
        fbpa_pkg::OP_INIT:      eff_nxt    = fbpa_pkg::eff_bytes(cfg.req_bytes);
        default: begin
        end
      endcase
    end

    if (state_r == fbpa_pkg::BK_DIV && div_done) begin
      total_nxt = div_q;
      count_nxt = div_q;
      top_nxt   = div_q;
      head_nxt  = fbpa_pkg::HEAD_EMPTY;
    end

    if (state_r == fbpa_pkg::BK_RES && link_pend_r) begin
      head_nxt      = ram_rdata;
      link_pend_nxt = 1'b0;
    end

    if (out_load) begin
      out_valid_nxt             = 1'b1;
      out_res_nxt.status        = status_r;
      out_res_nxt.block_index   = got_r;
      out_res_nxt.block_address = addr_en_r ? addr : '0;
      out_res_nxt.free_count    = count_r;
      out_res_nxt.blk_total     = total_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fbpa_pkg::BK_IDLE;
      head_r      <= fbpa_pkg::HEAD_EMPTY;
      top_r       <= '0;
      count_r     <= '0;
      total_r     <= '0;
      eff_r       <= EW'(fbpa_pkg::PTR_BYTES);
      link_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      top_r       <= top_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      eff_r       <= eff_nxt;
      link_pend_r <= link_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    got_r     <= got_nxt;
    status_r  <= status_nxt;
    addr_en_r <= addr_en_nxt;
    out_res_r <= out_res_nxt;
  end

  fbpa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (cfg.pool_bytes),
    .divisor  (fbpa_pkg::eff_bytes(cfg.req_bytes)),
    .done     (div_done),
    .quotient (div_q)
  );

  fbpa_ram #(
    .WIDTH (CW),
    .DEPTH (fbpa_pkg::MAX_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_op.idx[MW-1:0]),
    .wdata (head_r),
    .re    (ram_re),
    .raddr (head_r[MW-1:0]),
    .rdata (ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// File: rtl/core/fixed_block_pool_allocator_top.sv
// Fixed-size block pool allocator (LIFO free list of block indices). A front
// end decodes each request beat into a two-entry queue, so new requests are
// taken while the queue has room, even while the back end works or a result
// waits in the output register. The back end runs one operation at a time:
// alloc, free, null free and the unused code execute, then deliver; an alloc
// from the list reads the popped block's link from the link RAM as it executes
// and loads the new head from it while delivering. Init runs the restoring
// block-count divider (one quotient bit per cycle, with an early exit when the
// pool saturates). Sizes take effect at init, the base address at each result.
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_top
// Top level: configuration registers, front end, queue and back end.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [31:0]                  cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_func,
  input  logic [7:0]                   in_free_index,
  input  logic                         in_free_is_null,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [7:0]                   out_block_index,
  output logic [31:0]                  out_block_address,
  output logic [8:0]                   out_free_count,
  output logic [8:0]                   out_blk_total
);

  fbpa_pkg::cfg_t    cfg_r, cfg_nxt;
  fbpa_pkg::op_t     push_op;
  fbpa_pkg::op_t     head_op;
  fbpa_pkg::result_t res;
  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        fbpa_pkg::CFG_BASE:      cfg_nxt.base       = cfg_wdata;
        fbpa_pkg::CFG_REQ_BYTES: cfg_nxt.req_bytes  = cfg_wdata[fbpa_pkg::REQ_W-1:0];
        fbpa_pkg::CFG_BUF_BYTES: cfg_nxt.pool_bytes = cfg_wdata[fbpa_pkg::BUF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base       <= '0;
      cfg_r.req_bytes  <= fbpa_pkg::REQ_W'(fbpa_pkg::PTR_BYTES);
      cfg_r.pool_bytes <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fbpa_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_free_index   (in_free_index),
    .in_free_is_null (in_free_is_null),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_op            (push_op)
  );

  fbpa_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .head_op (head_op)
  );

  fbpa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_op      (head_op),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_status        = res.status;
  assign out_block_index   = res.block_index;
  assign out_block_address = res.block_address;
  assign out_free_count    = res.free_count;
  assign out_blk_total     = res.blk_total;

endmodule
